// ----- src/aosd_pkg.sv -----
// constants and codes for the orientation and double-shake detector
// no dependencies; used by the channel interfaces and the top level
package aosd_pkg;

    // item modes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_ACK    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // face encoding
    localparam logic [2:0] FACE_UNKNOWN = 3'd0;
    localparam logic [2:0] FACE_UP      = 3'd1;
    localparam logic [2:0] FACE_DOWN    = 3'd2;
    localparam logic [2:0] FACE_RIGHT   = 3'd3;
    localparam logic [2:0] FACE_LEFT    = 3'd4;
    localparam logic [2:0] FACE_TOP     = 3'd5;
    localparam logic [2:0] FACE_BOTTOM  = 3'd6;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TIME_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_HIGH_SQ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_LOW_SQ      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_MIN_GAP_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_MAX_GAP_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NUDGE_COOLDOWN_MS = 3'd6;

    localparam int CFG_DATA_W = 32;

    // configuration reset values
    localparam logic [14:0] RST_FACE_THRESHOLD    = 15'd2949;
    localparam logic [15:0] RST_STABLE_TIME_MS    = 16'd500;
    localparam logic [31:0] RST_SHAKE_HIGH_SQ     = 32'd49633716;
    localparam logic [31:0] RST_SHAKE_LOW_SQ      = 32'd1315334;
    localparam logic [15:0] RST_PEAK_MIN_GAP_MS   = 16'd160;
    localparam logic [15:0] RST_PEAK_MAX_GAP_MS   = 16'd900;
    localparam logic [15:0] RST_NUDGE_COOLDOWN_MS = 16'd1500;

endpackage

// ----- src/aosd_if.sv -----
// channel interfaces of the orientation and double-shake detector
// depends on aosd_pkg for the configuration port widths

interface aosd_sample_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [31:0]        timestamp_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               in_foreground;
    logic               gesture_enable;

    modport source (output valid, mode, timestamp_ms, accel_x, accel_y, accel_z,
                    in_foreground, gesture_enable, input ready);
    modport sink   (input valid, mode, timestamp_ms, accel_x, accel_y, accel_z,
                    in_foreground, gesture_enable, output ready);
endinterface

interface aosd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] detected_face;
    logic [2:0] stable_face;
    logic       stable_changed;
    logic       candidate_changed;
    logic       nudge_requested;
    logic       nudge_pending;

    modport source (output valid, detected_face, stable_face, stable_changed,
                    candidate_changed, nudge_requested, nudge_pending, input ready);
    modport sink   (input valid, detected_face, stable_face, stable_changed,
                    candidate_changed, nudge_requested, nudge_pending, output ready);
endinterface

interface aosd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [aosd_pkg::CFG_IDX_W-1:0]     index;
    logic [aosd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/accel_orientation_shake_detector_unit.sv -----
// accepted samples pass the stage and result registers, one per cycle unless
// the result side stalls; the stage register feeds the state update
// and result register, so each item sees the state left by the one before it
// reset (rst_n low, asynchronous): pipeline empty, state cleared, config at defaults
// configuration writes are always accepted and take effect on the next cycle
// depends on aosd_pkg and the channel interfaces in aosd_if.sv
module accel_orientation_shake_detector_unit (
    input  logic         clk,
    input  logic         rst_n,
    aosd_sample_if.sink  sample,
    aosd_result_if.source result,
    aosd_cfg_if.sink     cfg
);
    import aosd_pkg::*;

    // configuration registers
    logic [14:0] face_threshold_reg;
    logic [15:0] stable_time_ms_reg;
    logic [31:0] shake_high_sq_reg;
    logic [31:0] shake_low_sq_reg;
    logic [15:0] peak_min_gap_ms_reg;
    logic [15:0] peak_max_gap_ms_reg;
    logic [15:0] nudge_cooldown_ms_reg;

    // detector state
    logic [2:0]  candidate_face_reg,  candidate_face_next;
    logic [31:0] candidate_since_reg, candidate_since_next;
    logic [2:0]  stable_face_reg,     stable_face_next;
    logic        peak_count_reg,      peak_count_next;
    logic [31:0] last_peak_time_reg,  last_peak_time_next;
    logic        pending_reg,         pending_next;
    logic [31:0] cooldown_until_reg,  cooldown_until_next;

    // input stage register: raw fields plus the per-axis squares
    logic               stage_valid_reg;
    logic [1:0]         mode_reg;
    logic [31:0]        ts_reg;
    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [15:0] az_reg;
    logic               fg_reg;
    logic               gest_reg;
    logic [30:0]        sqx_reg;
    logic [30:0]        sqy_reg;
    logic [30:0]        sqz_reg;

    // result register
    logic       out_valid_reg;
    logic [2:0] out_detected_reg,  out_detected_next;
    logic       out_st_chg_reg,    out_st_chg_next;
    logic       out_cand_chg_reg,  out_cand_chg_next;
    logic       out_requested_reg, out_requested_next;

    logic advance;
    logic stage_fire;
    logic sample_take;

    // squares of the incoming axes, computed ahead of the stage register
    logic signed [31:0] sq_x_in;
    logic signed [31:0] sq_y_in;
    logic signed [31:0] sq_z_in;

    // ---------------------------------------------------------------
    // handshake: result register empties or drains, stage moves forward
    // ---------------------------------------------------------------
    assign advance     = !out_valid_reg || result.ready;
    assign stage_fire  = stage_valid_reg && advance;
    assign sample.ready = !stage_valid_reg || advance;
    assign sample_take = sample.valid && sample.ready;
    assign cfg.ready   = 1'b1;

    assign sq_x_in = sample.accel_x * sample.accel_x;
    assign sq_y_in = sample.accel_y * sample.accel_y;
    assign sq_z_in = sample.accel_z * sample.accel_z;

    // ---------------------------------------------------------------
    // configuration write transactions
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_threshold_reg    <= RST_FACE_THRESHOLD;
            stable_time_ms_reg    <= RST_STABLE_TIME_MS;
            shake_high_sq_reg     <= RST_SHAKE_HIGH_SQ;
            shake_low_sq_reg      <= RST_SHAKE_LOW_SQ;
            peak_min_gap_ms_reg   <= RST_PEAK_MIN_GAP_MS;
            peak_max_gap_ms_reg   <= RST_PEAK_MAX_GAP_MS;
            nudge_cooldown_ms_reg <= RST_NUDGE_COOLDOWN_MS;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_FACE_THRESHOLD:    face_threshold_reg    <= cfg.data[14:0];
                CFG_STABLE_TIME_MS:    stable_time_ms_reg    <= cfg.data[15:0];
                CFG_SHAKE_HIGH_SQ:     shake_high_sq_reg     <= cfg.data;
                CFG_SHAKE_LOW_SQ:      shake_low_sq_reg      <= cfg.data;
                CFG_PEAK_MIN_GAP_MS:   peak_min_gap_ms_reg   <= cfg.data[15:0];
                CFG_PEAK_MAX_GAP_MS:   peak_max_gap_ms_reg   <= cfg.data[15:0];
                CFG_NUDGE_COOLDOWN_MS: nudge_cooldown_ms_reg <= cfg.data[15:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input stage register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            stage_valid_reg <= sample.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            mode_reg <= sample.mode;
            ts_reg   <= sample.timestamp_ms;
            ax_reg   <= sample.accel_x;
            ay_reg   <= sample.accel_y;
            az_reg   <= sample.accel_z;
            fg_reg   <= sample.in_foreground;
            gest_reg <= sample.gesture_enable;
            // a square of a 16-bit value is at most 2^30
            sqx_reg  <= sq_x_in[30:0];
            sqy_reg  <= sq_y_in[30:0];
            sqz_reg  <= sq_z_in[30:0];
        end
    end

    // ---------------------------------------------------------------
    // single-pass evaluation of the item in the stage register
    // ---------------------------------------------------------------
    logic        is_sample;
    logic        shake_check;
    logic [31:0] mag_sq;
    logic        peak;
    logic [31:0] gap;
    logic        peak_hit;
    logic        second_peak;
    logic [31:0] cool_diff;
    logic        cooldown_over;
    logic [15:0] abs_x, abs_y, abs_z;
    logic [15:0] abs_max;
    logic [2:0]  face;
    logic [31:0] held_for;

    always_comb
    begin
        // magnitudes; -32768 maps to 32768, which still fits 16 unsigned bits
        abs_x = ax_reg[15] ? 16'(-ax_reg) : 16'(ax_reg);
        abs_y = ay_reg[15] ? 16'(-ay_reg) : 16'(ay_reg);
        abs_z = az_reg[15] ? 16'(-az_reg) : 16'(az_reg);

        abs_max = abs_x;
        if (abs_y > abs_max)
        begin
            abs_max = abs_y;
        end
        if (abs_z > abs_max)
        begin
            abs_max = abs_z;
        end

        // z wins ties, then x over y; a non-negative axis is the positive face
        priority if (abs_max < {1'b0, face_threshold_reg})
        begin
            face = FACE_UNKNOWN;
        end
        else if (abs_z >= abs_x && abs_z >= abs_y)
        begin
            face = az_reg[15] ? FACE_DOWN : FACE_UP;
        end
        else if (abs_x >= abs_y)
        begin
            face = ax_reg[15] ? FACE_LEFT : FACE_RIGHT;
        end
        else
        begin
            face = ay_reg[15] ? FACE_BOTTOM : FACE_TOP;
        end
    end

    always_comb
    begin
        is_sample   = (mode_reg == MODE_SAMPLE) && fg_reg;
        shake_check = is_sample && gest_reg && !pending_reg;

        // squared magnitude Q8.24, at most 3 * 2^30 so no overflow
        mag_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg} + {1'b0, sqz_reg};
        peak   = (mag_sq >= shake_high_sq_reg) || (mag_sq <= shake_low_sq_reg);

        // time differences wrap modulo 2^32
        gap      = ts_reg - last_peak_time_reg;
        peak_hit = shake_check && peak && (gap >= {16'd0, peak_min_gap_ms_reg});
        second_peak = peak_count_reg && (gap <= {16'd0, peak_max_gap_ms_reg});

        // cooldown still running while the signed distance is negative
        cool_diff     = ts_reg - cooldown_until_reg;
        cooldown_over = !cool_diff[31];

        held_for = ts_reg - candidate_since_reg;

        candidate_face_next  = candidate_face_reg;
        candidate_since_next = candidate_since_reg;
        stable_face_next     = stable_face_reg;
        peak_count_next      = peak_count_reg;
        last_peak_time_next  = last_peak_time_reg;
        pending_next         = pending_reg;
        cooldown_until_next  = cooldown_until_reg;

        out_detected_next  = FACE_UNKNOWN;
        out_st_chg_next    = 1'b0;
        out_cand_chg_next  = 1'b0;
        out_requested_next = 1'b0;

        if (is_sample)
        begin
            // double-shake tracking
            if (peak_hit)
            begin
                last_peak_time_next = ts_reg;
                if (second_peak)
                begin
                    peak_count_next = 1'b0;
                    if (cooldown_over)
                    begin
                        pending_next        = 1'b1;
                        cooldown_until_next = ts_reg + {16'd0, nudge_cooldown_ms_reg};
                        out_requested_next  = 1'b1;
                    end
                end
                else
                begin
                    peak_count_next = 1'b1;
                end
            end

            // orientation tracking
            out_detected_next = face;
            if (face != candidate_face_reg)
            begin
                candidate_face_next  = face;
                candidate_since_next = ts_reg;
                out_cand_chg_next    = 1'b1;
            end
            else if (face != FACE_UNKNOWN &&
                     held_for >= {16'd0, stable_time_ms_reg} &&
                     stable_face_reg != face)
            begin
                stable_face_next = face;
                out_st_chg_next  = 1'b1;
            end
        end
        else if (mode_reg == MODE_ACK)
        begin
            // acknowledge clears the flag; harmless when nothing is pending
            pending_next = 1'b0;
        end
        else if (mode_reg == MODE_CLEAR)
        begin
            peak_count_next = 1'b0;
        end
        // unused mode and background samples leave the state alone
    end

    // ---------------------------------------------------------------
    // state update, one item per stage transaction
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidate_face_reg  <= FACE_UNKNOWN;
            candidate_since_reg <= 32'd0;
            stable_face_reg     <= FACE_UNKNOWN;
            peak_count_reg      <= 1'b0;
            last_peak_time_reg  <= 32'd0;
            pending_reg         <= 1'b0;
            cooldown_until_reg  <= 32'd0;
        end
        else if (stage_fire)
        begin
            candidate_face_reg  <= candidate_face_next;
            candidate_since_reg <= candidate_since_next;
            stable_face_reg     <= stable_face_next;
            peak_count_reg      <= peak_count_next;
            last_peak_time_reg  <= last_peak_time_next;
            pending_reg         <= pending_next;
            cooldown_until_reg  <= cooldown_until_next;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            out_detected_reg  <= out_detected_next;
            out_st_chg_reg    <= out_st_chg_next;
            out_cand_chg_reg  <= out_cand_chg_next;
            out_requested_reg <= out_requested_next;
        end
    end

    // stable face and pending flag are the state left by the last item,
    // which is exactly the item held in the result register
    assign result.valid             = out_valid_reg;
    assign result.detected_face     = out_detected_reg;
    assign result.stable_face       = stable_face_reg;
    assign result.stable_changed    = out_st_chg_reg;
    assign result.candidate_changed = out_cand_chg_reg;
    assign result.nudge_requested   = out_requested_reg;
    assign result.nudge_pending     = pending_reg;

endmodule

// ----- dv/accel_orientation_shake_detector_unit_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the orientation and double-shake detector: directed and random
// transactions checked against an in-bench predictor of faces, stable face and nudge requests
// depends on aosd_pkg, the channel interfaces in aosd_if.sv and the detector top level

module accel_orientation_shake_detector_unit_test;
    import aosd_pkg::*;

    // mode 3 has no name in the package; the block ignores it
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int PIPE_LATENCY = 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TRAFFIC_PER_SETTING = 190;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        timestamp_ms;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic               in_foreground;
        logic               gesture_enable;
    } accel_item_t;

    typedef struct packed {
        logic [2:0] detected_face;
        logic [2:0] stable_face;
        logic       stable_changed;
        logic       candidate_changed;
        logic       nudge_requested;
        logic       nudge_pending;
    } face_report_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    aosd_sample_if sample_bus();
    aosd_result_if result_bus();
    aosd_cfg_if    cfg_bus();

    accel_orientation_shake_detector_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // predictor copy of the register file, starting at the reset values
    logic [14:0] thr_face      = RST_FACE_THRESHOLD;
    logic [15:0] settle_ms     = RST_STABLE_TIME_MS;
    logic [31:0] high_sq_bound = RST_SHAKE_HIGH_SQ;
    logic [31:0] low_sq_bound  = RST_SHAKE_LOW_SQ;
    logic [15:0] min_gap_ms    = RST_PEAK_MIN_GAP_MS;
    logic [15:0] max_gap_ms    = RST_PEAK_MAX_GAP_MS;
    logic [15:0] cooldown_ms   = RST_NUDGE_COOLDOWN_MS;

    // predictor copy of the detector state
    logic [2:0]  cand_face         = FACE_UNKNOWN;
    logic [31:0] cand_since_ms     = '0;
    logic [2:0]  settled_face      = FACE_UNKNOWN;
    logic        peak_armed        = 1'b0;
    logic [31:0] last_peak_ms      = '0;
    logic        nudge_outstanding = 1'b0;
    logic [31:0] cooldown_end_ms   = '0;

    face_report_t expected_reports[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatch_count     = 0;
    int items_sent         = 0;
    int results_checked    = 0;
    int nudges_seen        = 0;
    int stable_changes     = 0;
    int settings_applied   = 0;
    int quiet_cycles       = 0;
    logic [31:0] traffic_clock_ms = 32'h0000_0200;

    // next state and expected result for one accepted transaction
    function automatic face_report_t predict_detector(input accel_item_t s);
        face_report_t r;
        logic signed [31:0] sx, sy, sz;
        logic [31:0] energy;
        logic [31:0] gap;
        logic [31:0] cool_diff;
        logic [16:0] mx, my, mz, mmax;
        logic [2:0]  face;
        logic        is_peak;
        r = '0;
        if (s.mode == MODE_SAMPLE && s.in_foreground)
        begin
            sx = s.accel_x;
            sy = s.accel_y;
            sz = s.accel_z;
            // shake detection runs before classification and only with no nudge outstanding
            if (s.gesture_enable && !nudge_outstanding)
            begin
                // squared magnitude in q8.24, sum taken modulo 2^32
                energy = 32'(sx * sx) + 32'(sy * sy) + 32'(sz * sz);
                is_peak = (energy >= high_sq_bound) || (energy <= low_sq_bound);
                gap = s.timestamp_ms - last_peak_ms;
                if (is_peak && gap >= {16'd0, min_gap_ms})
                begin
                    if (!peak_armed || gap > {16'd0, max_gap_ms})
                        peak_armed = 1'b1;
                    else
                    begin
                        // second peak in the window: a double shake
                        peak_armed = 1'b0;
                        cool_diff = s.timestamp_ms - cooldown_end_ms;
                        if (!cool_diff[31])
                        begin
                            nudge_outstanding = 1'b1;
                            cooldown_end_ms = s.timestamp_ms + {16'd0, cooldown_ms};
                            r.nudge_requested = 1'b1;
                        end
                    end
                    last_peak_ms = s.timestamp_ms;
                end
            end
            // largest axis wins; ties favour z, then x
            mx = (sx < 0) ? 17'(-sx) : 17'(sx);
            my = (sy < 0) ? 17'(-sy) : 17'(sy);
            mz = (sz < 0) ? 17'(-sz) : 17'(sz);
            mmax = mx;
            if (my > mmax)
                mmax = my;
            if (mz > mmax)
                mmax = mz;
            if (mmax < {2'b00, thr_face})
                face = FACE_UNKNOWN;
            else if (mz >= mx && mz >= my)
                face = (sz >= 0) ? FACE_UP : FACE_DOWN;
            else if (mx >= my)
                face = (sx >= 0) ? FACE_RIGHT : FACE_LEFT;
            else
                face = (sy >= 0) ? FACE_TOP : FACE_BOTTOM;
            r.detected_face = face;
            if (face != cand_face)
            begin
                cand_face = face;
                cand_since_ms = s.timestamp_ms;
                r.candidate_changed = 1'b1;
            end
            else if (face != FACE_UNKNOWN &&
                     (s.timestamp_ms - cand_since_ms) >= {16'd0, settle_ms} &&
                     settled_face != face)
            begin
                settled_face = face;
                r.stable_changed = 1'b1;
            end
        end
        else if (s.mode == MODE_ACK)
            nudge_outstanding = 1'b0;
        else if (s.mode == MODE_CLEAR)
            peak_armed = 1'b0;
        r.stable_face = settled_face;
        r.nudge_pending = nudge_outstanding;
        return r;
    endfunction

    function automatic accel_item_t make_item(input logic [1:0] mode, input logic [31:0] ts,
                                              input logic signed [15:0] x,
                                              input logic signed [15:0] y,
                                              input logic signed [15:0] z,
                                              input logic fg, input logic ge);
        accel_item_t s;
        s.mode = mode;
        s.timestamp_ms = ts;
        s.accel_x = x;
        s.accel_y = y;
        s.accel_z = z;
        s.in_foreground = fg;
        s.gesture_enable = ge;
        return s;
    endfunction

    // random transaction: mostly well-formed motion on an advancing clock, some noise
    function automatic accel_item_t next_random_item();
        accel_item_t s;
        int pick;
        int spread;
        int axis;
        int vals[3];
        logic [31:0] step;
        pick = $urandom_range(99);
        s = '0;
        s.mode = MODE_SAMPLE;
        s.timestamp_ms = traffic_clock_ms;
        s.in_foreground = 1'b1;
        s.gesture_enable = 1'b1;
        if (pick < 10)
        begin
            // noise: any value the fields allow, unused mode included
            s.mode = 2'($urandom_range(3));
            s.timestamp_ms = $urandom;
            s.accel_x = 16'($urandom);
            s.accel_y = 16'($urandom);
            s.accel_z = 16'($urandom);
            s.in_foreground = 1'($urandom_range(1));
            s.gesture_enable = 1'($urandom_range(1));
            return s;
        end
        if (pick < 14 || (nudge_outstanding && pick < 35))
        begin
            s.mode = MODE_ACK;
            return s;
        end
        if (pick < 17)
        begin
            s.mode = MODE_CLEAR;
            return s;
        end
        // time step spread around the peak window, with rare long jumps and wraps
        spread = $urandom_range(19);
        if (spread < 8)
            step = $urandom_range(150);
        else if (spread < 16)
            step = $urandom_range(1000, 100);
        else if (spread < 19)
            step = $urandom_range(3000, 1000);
        else
            step = $urandom;
        traffic_clock_ms = traffic_clock_ms + step;
        s.timestamp_ms = traffic_clock_ms;
        s.in_foreground = ($urandom_range(29) != 0);
        s.gesture_enable = ($urandom_range(19) != 0);
        axis = $urandom_range(2);
        for (int k = 0; k < 3; k++)
            vals[k] = int'($urandom_range(1200)) - 600;
        if ($urandom_range(99) < 45)
        begin
            // motion peak: free fall or a hard jolt
            if ($urandom_range(1))
            begin
                for (int k = 0; k < 3; k++)
                    vals[k] = int'($urandom_range(1000)) - 500;
            end
            else
                vals[axis] = int'($urandom_range(32767, 7200));
        end
        else
            vals[axis] = int'($urandom_range(6000, 3000));
        if ($urandom_range(1))
            vals[axis] = -vals[axis];
        s.accel_x = 16'(vals[0]);
        s.accel_y = 16'(vals[1]);
        s.accel_z = 16'(vals[2]);
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // one sample transaction, with random idle cycles ahead of it
    task automatic send_item(input accel_item_t s);
        face_report_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid          <= 1'b1;
        sample_bus.mode           <= s.mode;
        sample_bus.timestamp_ms   <= s.timestamp_ms;
        sample_bus.accel_x        <= s.accel_x;
        sample_bus.accel_y        <= s.accel_y;
        sample_bus.accel_z        <= s.accel_z;
        sample_bus.in_foreground  <= s.in_foreground;
        sample_bus.gesture_enable <= s.gesture_enable;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        r = predict_detector(s);
        expected_reports.push_back(r);
        items_sent++;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain_results(input int settle);
        sample_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            CFG_FACE_THRESHOLD:    thr_face = value[14:0];
            CFG_STABLE_TIME_MS:    settle_ms = value[15:0];
            CFG_SHAKE_HIGH_SQ:     high_sq_bound = value;
            CFG_SHAKE_LOW_SQ:      low_sq_bound = value;
            CFG_PEAK_MIN_GAP_MS:   min_gap_ms = value[15:0];
            CFG_PEAK_MAX_GAP_MS:   max_gap_ms = value[15:0];
            CFG_NUDGE_COOLDOWN_MS: cooldown_ms = value[15:0];
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers are only written with the pipeline empty
    task automatic apply_setting(input logic [14:0] thr, input logic [15:0] settle,
                                 input logic [31:0] hi_sq, input logic [31:0] lo_sq,
                                 input logic [15:0] gap_lo, input logic [15:0] gap_hi,
                                 input logic [15:0] cool);
        drain_results(PIPE_LATENCY + 2);
        write_register(CFG_FACE_THRESHOLD, {17'd0, thr});
        write_register(CFG_STABLE_TIME_MS, {16'd0, settle});
        write_register(CFG_SHAKE_HIGH_SQ, hi_sq);
        write_register(CFG_SHAKE_LOW_SQ, lo_sq);
        write_register(CFG_PEAK_MIN_GAP_MS, {16'd0, gap_lo});
        write_register(CFG_PEAK_MAX_GAP_MS, {16'd0, gap_hi});
        write_register(CFG_NUDGE_COOLDOWN_MS, {16'd0, cool});
        settings_applied++;
    endtask

    // full-scale axes, tie breaks and the face threshold edge, gestures off
    task automatic test_face_extremes();
        send_item(make_item(MODE_SAMPLE, 32'd100, 16'sd32767, 16'sd0, 16'sd0, 1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd110, -16'sd32768, 16'sd0, 16'sd0, 1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd120, 16'sd0, 16'sd32767, 16'sd0, 1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd130, 16'sd0, -16'sd32768, 16'sd0, 1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd140, 16'sd0, 16'sd0, -16'sd32768, 1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd150, -16'sd32768, -16'sd32768, -16'sd32768,
                            1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd160, 16'sd4096, 16'sd4096, 16'sd0, 1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd170, 16'sd4096, -16'sd4096, 16'sd4096, 1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd180, 16'sd2948, 16'sd0, 16'sd0, 1'b1, 1'b0));
        send_item(make_item(MODE_SAMPLE, 32'd190, 16'sd2949, 16'sd0, 16'sd0, 1'b1, 1'b0));
    endtask

    // background sample, acknowledge with nothing pending, clear, unused mode
    task automatic test_mode_handling();
        send_item(make_item(MODE_SAMPLE, 32'd300, 16'sd0, 16'sd0, 16'sd4096, 1'b0, 1'b1));
        send_item(make_item(MODE_ACK, 32'd310, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_CLEAR, 32'd320, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_UNUSED, 32'hFFFF_FFFF, -16'sd1, -16'sd1, -16'sd1, 1'b1, 1'b1));
    endtask

    // double shake with a too-close peak, skipped while pending, refused in cooldown
    task automatic test_double_shake();
        send_item(make_item(MODE_SAMPLE, 32'd2000, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_SAMPLE, 32'd2100, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_SAMPLE, 32'd2400, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_SAMPLE, 32'd2600, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_ACK, 32'd2700, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_SAMPLE, 32'd2900, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_SAMPLE, 32'd3100, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_SAMPLE, 32'd4000, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_item(make_item(MODE_SAMPLE, 32'd4500, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
    endtask

    // face held across the wrap of the millisecond counter becomes stable
    task automatic test_stable_face_time_wrap();
        send_item(make_item(MODE_SAMPLE, 32'hFFFF_FF00, 16'sd0, 16'sd0, 16'sd4096, 1'b1, 1'b1));
        send_item(make_item(MODE_SAMPLE, 32'h0000_0100, 16'sd0, 16'sd0, 16'sd4096, 1'b1, 1'b1));
    endtask

    task automatic run_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            // hold off once mid-stream until every result is back
            if (i == count / 2)
                drain_results(0);
            send_item(next_random_item());
        end
    endtask

    // random traffic under the defaults, both extremes and mixed settings
    task automatic test_register_sweep();
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0: apply_setting(RST_FACE_THRESHOLD, RST_STABLE_TIME_MS, RST_SHAKE_HIGH_SQ,
                                 RST_SHAKE_LOW_SQ, RST_PEAK_MIN_GAP_MS, RST_PEAK_MAX_GAP_MS,
                                 RST_NUDGE_COOLDOWN_MS);
                1: apply_setting(15'd0, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
                2: apply_setting(15'd32767, 16'd65535, 32'hC000_0000, 32'hC000_0000,
                                 16'd65535, 16'd65535, 16'd65535);
                3: apply_setting(15'($urandom_range(4500, 1500)), 16'd50, RST_SHAKE_HIGH_SQ,
                                 RST_SHAKE_LOW_SQ, 16'd20, 16'd300, 16'd100);
                default: apply_setting(15'($urandom_range(4500, 1500)),
                                       16'($urandom_range(1200)),
                                       $urandom_range(80_000_000, 30_000_000),
                                       $urandom_range(4_000_000),
                                       16'($urandom_range(300)),
                                       16'($urandom_range(1500, 300)),
                                       16'($urandom_range(3000)));
            endcase
            // idling pattern rotates with the setting
            case (k % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 76;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 76;
                end
                default:
                begin
                    sender_idle_pct = 33;
                    receiver_stall_pct = 33;
                end
            endcase
            run_traffic(TRAFFIC_PER_SETTING);
        end
    endtask

    // receiver back-pressure
    always @(posedge clk)
        result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);

    // each result transaction against the oldest expectation
    always @(posedge clk)
    begin : result_compare
        face_report_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = expected_reports.pop_front();
                if (result_bus.detected_face !== want.detected_face)
                    report_mismatch($sformatf("detected_face expected %0d got %0d",
                                              want.detected_face, result_bus.detected_face));
                if (result_bus.stable_face !== want.stable_face)
                    report_mismatch($sformatf("stable_face expected %0d got %0d",
                                              want.stable_face, result_bus.stable_face));
                if (result_bus.stable_changed !== want.stable_changed)
                    report_mismatch($sformatf("stable_changed expected %0b got %0b",
                                              want.stable_changed, result_bus.stable_changed));
                if (result_bus.candidate_changed !== want.candidate_changed)
                    report_mismatch($sformatf("candidate_changed expected %0b got %0b",
                                              want.candidate_changed,
                                              result_bus.candidate_changed));
                if (result_bus.nudge_requested !== want.nudge_requested)
                    report_mismatch($sformatf("nudge_requested expected %0b got %0b",
                                              want.nudge_requested, result_bus.nudge_requested));
                if (result_bus.nudge_pending !== want.nudge_pending)
                    report_mismatch($sformatf("nudge_pending expected %0b got %0b",
                                              want.nudge_pending, result_bus.nudge_pending));
                results_checked++;
                if (want.nudge_requested)
                    nudges_seen++;
                if (want.stable_changed)
                    stable_changes++;
            end
        end
    end

    // watchdog: too long without any transaction on any channel ends the run
    always @(posedge clk)
    begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", expected_reports.size());
            $display("accel_orientation_shake_detector_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        // every sample and configuration input known from the start, reset held low and then released
        rst_n                     <= 1'b0;
        sample_bus.valid          <= 1'b0;
        sample_bus.mode           <= MODE_SAMPLE;
        sample_bus.timestamp_ms   <= '0;
        sample_bus.accel_x        <= '0;
        sample_bus.accel_y        <= '0;
        sample_bus.accel_z        <= '0;
        sample_bus.in_foreground  <= 1'b0;
        sample_bus.gesture_enable <= 1'b0;
        cfg_bus.valid             <= 1'b0;
        cfg_bus.index             <= CFG_FACE_THRESHOLD;
        cfg_bus.data              <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_face_extremes();
        test_mode_handling();
        test_double_shake();
        test_stable_face_time_wrap();
        test_register_sweep();

        // let the pipeline empty and watch for stray results
        drain_results(PIPE_LATENCY + 4);

        $display("covered %0d sample transactions over %0d register settings",
                 items_sent, settings_applied);
        $display("%0d results checked, %0d nudge requests, %0d stable face changes, %0d mismatches",
                 results_checked, nudges_seen, stable_changes, mismatch_count);
        if (mismatch_count == 0)
            $display("accel_orientation_shake_detector_unit verification clean");
        else
            $display("accel_orientation_shake_detector_unit verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/aosd_pkg.sv
src/aosd_if.sv
src/accel_orientation_shake_detector_unit.sv
dv/accel_orientation_shake_detector_unit_test.sv
